FILE: rtl/efgr_pkg.sv
// shared types, codes and reset tables for the editable state machine block
// no dependencies; imported by every other file of the block
package efgr_pkg;

  localparam int NUM_STATES = 8;
  localparam int STATE_W    = 3;
  localparam int PASS_W     = $clog2(NUM_STATES);

  typedef logic [STATE_W-1:0]    state_idx_t;
  typedef logic [NUM_STATES-1:0] state_mask_t;

  // reset contents of the next-state table
  localparam state_idx_t RESET_ZERO [NUM_STATES] =
    '{3'd3, 3'd7, 3'd4, 3'd2, 3'd0, 3'd6, 3'd7, 3'd5};
  localparam state_idx_t RESET_ONE [NUM_STATES] =
    '{3'd1, 3'd6, 3'd2, 3'd5, 3'd1, 3'd3, 3'd2, 3'd0};
  localparam state_idx_t RESET_STATE = 3'd1;

  typedef enum logic [2:0] {
    CMD_STEP     = 3'd0,
    CMD_CHANGE   = 3'd1,
    CMD_IDENTIFY = 3'd2,
    CMD_DEL_GARB = 3'd3,
    CMD_DEL_ONE  = 3'd4,
    CMD_READ     = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_IGNORED = 2'd1,
    STS_DELETED = 2'd2,
    STS_NONE    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_CLOSE,
    FSM_EXEC
  } fsm_e;

  typedef struct packed {
    logic [2:0] command;
    logic       path_bit;
    state_idx_t target_state;
    state_idx_t state_index;
  } cmd_pld_t;

  typedef struct packed {
    state_idx_t  cur_state;
    state_idx_t  row_next_zero;
    state_idx_t  row_next_one;
    logic        row_deleted;
    logic [7:0]  garbage_mask;
    logic [1:0]  status;
  } res_pld_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic iterate;
    logic execute;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_closure;
    logic closure_done;
  } ctrl_sts_t;

endpackage

FILE: rtl/efgr_cmd_if.sv
// command channel: valid/ready handshake carrying one command item
// depends on efgr_pkg
interface efgr_cmd_if;
  logic                valid;
  logic                ready;
  efgr_pkg::cmd_pld_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/efgr_res_if.sv
// result channel: valid/ready handshake carrying one result item
// depends on efgr_pkg
interface efgr_res_if;
  logic                valid;
  logic                ready;
  efgr_pkg::res_pld_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/efgr_ctrl.sv
// sequencing state machine: accept, closure passes, execute, result flag
// depends on efgr_pkg
module efgr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  efgr_pkg::ctrl_sts_t  sts_i,
  output efgr_pkg::ctrl_cmd_t  ctrl_o
);
  import efgr_pkg::*;

  fsm_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    ctrl_o      = '0;
    case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = sts_i.needs_closure ? FSM_CLOSE : FSM_EXEC;
        end
      end
      FSM_CLOSE: begin
        ctrl_o.iterate = 1'b1;
        if (sts_i.closure_done) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        // wait for the result register to be free
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.execute = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/efgr_dp.sv
// datapath: state table, deleted flags, reachability register, result register
// depends on efgr_pkg
module efgr_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  efgr_pkg::cmd_pld_t   in_pld_i,
  input  efgr_pkg::ctrl_cmd_t  ctrl_i,
  output efgr_pkg::ctrl_sts_t  sts_o,
  output efgr_pkg::res_pld_t   res_o
);
  import efgr_pkg::*;

  cmd_pld_t    cmd_q;
  state_idx_t  present_q, present_d;
  state_idx_t  nz_q [NUM_STATES];
  state_idx_t  nz_d [NUM_STATES];
  state_idx_t  no_q [NUM_STATES];
  state_idx_t  no_d [NUM_STATES];
  state_mask_t del_q, del_d;
  state_mask_t gset_q, gset_d;
  logic        gvalid_q, gvalid_d;
  state_mask_t seen_q, seen_d;
  logic [PASS_W-1:0] pass_q;
  res_pld_t    res_q, res_d;

  state_idx_t  row_sel;
  state_idx_t  row_zero, row_one;
  state_mask_t garbage;
  state_mask_t spread;

  // one propagation pass over all live reached states
  always_comb begin
    spread = '0;
    for (int i = 0; i < NUM_STATES; i++) begin
      if (seen_q[i] && !del_q[i]) begin
        spread = spread | (state_mask_t'(1) << nz_q[i]) | (state_mask_t'(1) << no_q[i]);
      end
    end
    seen_d = seen_q | spread;
  end

  assign garbage = ~seen_q & ~del_q;

  // single row read port
  assign row_sel  = (cmd_q.command == CMD_READ) ? cmd_q.state_index : present_q;
  assign row_zero = nz_q[row_sel];
  assign row_one  = no_q[row_sel];

  always_comb begin
    present_d = present_q;
    nz_d      = nz_q;
    no_d      = no_q;
    del_d     = del_q;
    gset_d    = gset_q;
    gvalid_d  = gvalid_q;
    res_d     = '0;
    res_d.status = STS_DONE;
    case (cmd_q.command)
      CMD_STEP: begin
        if (!del_q[present_q]) begin
          present_d = cmd_q.path_bit ? row_one : row_zero;
        end else begin
          res_d.status = STS_IGNORED;
        end
      end
      CMD_CHANGE: begin
        if (!del_q[present_q]) begin
          if (cmd_q.path_bit) begin
            no_d[present_q] = cmd_q.target_state;
          end else begin
            nz_d[present_q] = cmd_q.target_state;
          end
        end else begin
          res_d.status = STS_IGNORED;
        end
      end
      CMD_IDENTIFY: begin
        gset_d   = garbage;
        gvalid_d = 1'b1;
      end
      CMD_DEL_GARB: begin
        if (gvalid_q) begin
          del_d        = del_q | gset_q;
          gvalid_d     = 1'b0;
          res_d.status = (gset_q != '0) ? STS_DELETED : STS_NONE;
        end else begin
          res_d.status = STS_NONE;
        end
      end
      CMD_DEL_ONE: begin
        if (garbage[cmd_q.state_index]) begin
          del_d[cmd_q.state_index] = 1'b1;
          res_d.status             = STS_DELETED;
        end else begin
          res_d.status = STS_NONE;
        end
      end
      CMD_READ: begin
        res_d.row_next_zero = row_zero;
        res_d.row_next_one  = row_one;
        res_d.row_deleted   = del_q[cmd_q.state_index];
      end
      default: begin
        res_d.status = STS_IGNORED;
      end
    endcase
    res_d.cur_state    = present_d;
    res_d.garbage_mask = gvalid_d ? 8'(gset_d) : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= RESET_STATE;
      del_q     <= '0;
      gset_q    <= '0;
      gvalid_q  <= 1'b0;
      for (int i = 0; i < NUM_STATES; i++) begin
        nz_q[i] <= RESET_ZERO[i];
        no_q[i] <= RESET_ONE[i];
      end
    end else if (ctrl_i.execute) begin
      present_q <= present_d;
      del_q     <= del_d;
      gset_q    <= gset_d;
      gvalid_q  <= gvalid_d;
      nz_q      <= nz_d;
      no_q      <= no_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= '0;
    end else if (ctrl_i.load) begin
      pass_q <= '0;
    end else if (ctrl_i.iterate) begin
      pass_q <= pass_q + 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= in_pld_i;
      seen_q <= state_mask_t'(1) << present_q;
    end else if (ctrl_i.iterate) begin
      seen_q <= seen_d;
    end
    if (ctrl_i.execute) begin
      res_q <= res_d;
    end
  end

  assign sts_o.needs_closure = (in_pld_i.command == CMD_IDENTIFY) ||
                               (in_pld_i.command == CMD_DEL_ONE);
  assign sts_o.closure_done  = (pass_q == PASS_W'(NUM_STATES - 1));
  assign res_o               = res_q;

endmodule

FILE: rtl/editable_fsm_with_garbage_reclaim_unit.sv
// editable eight-state machine with garbage reclaim: top level
// step, change, delete-garbage and read go from accept straight to execute, which loads the
// result register; identify and delete-one first run eight reachability passes
// the next command is taken while a result waits, then stalls before execute until that
// result's transfer
// reset (async, active low): state B, table reloaded to its initial rows, nothing deleted
module editable_fsm_with_garbage_reclaim_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  efgr_cmd_if.sink    cmd_i,
  efgr_res_if.source  res_o
);
  import efgr_pkg::*;

  // control and status between sequencer and datapath
  ctrl_cmd_t ctrl;
  ctrl_sts_t sts;

  // sequencer: owns both handshakes and the closure pass sequence
  efgr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .ctrl_o      (ctrl)
  );

  // datapath: table, flags, reachability mask and result register
  efgr_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_pld_i (cmd_i.payload),
    .ctrl_i   (ctrl),
    .sts_o    (sts),
    .res_o    (res_o.payload)
  );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// testbench for the editable state machine with garbage reclaim
// needs efgr_pkg, efgr_cmd_if, efgr_res_if and the top level of the block
module tb_top;
  import efgr_pkg::*;

  // command codes the block does not know, used to check that they are ignored
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam int RANDOM_CMDS = 800;
  localparam int MAX_WAIT    = 15;
  localparam int IDLE_LIMIT  = 2000;  // cycles without any transfer before giving up
  localparam int DRAIN_CYCLES = 24;   // quiet tail, longer than a closure command
  localparam int MIN_LIVE    = 4;     // random deletions never shrink the machine below this

  // everything the block remembers, kept by the testbench on its own
  typedef struct packed {
    state_idx_t                         cur;
    logic [NUM_STATES-1:0][STATE_W-1:0] on_zero;
    logic [NUM_STATES-1:0][STATE_W-1:0] on_one;
    state_mask_t                        dead;
    state_mask_t                        garb;
    logic                               garb_ok;
  } table_image_t;

  logic clk_i;
  logic rst_ni;

  efgr_cmd_if cmd_ch ();
  efgr_res_if res_ch ();

  editable_fsm_with_garbage_reclaim_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch),
    .res_o  (res_ch)
  );

  cmd_pld_t     cmd_backlog [$];      // commands waiting to be driven
  res_pld_t     pending_results [$];  // predicted results, oldest first
  table_image_t plan_img;             // image used while building the stimulus
  table_image_t tracked_img;          // image advanced on each accepted command
  int           errors;
  int           cmds_taken;
  int           results_seen;
  int           deletions;
  int           src_wait;
  bit           src_burst;
  int           snk_wait;
  int           snk_draw;
  bit           snk_burst;
  int           idle_cycles;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic table_image_t image_after_reset();
    table_image_t m;
    m = '0;
    m.cur = RESET_STATE;
    for (int s = 0; s < NUM_STATES; s++) begin
      m.on_zero[s] = RESET_ZERO[s];
      m.on_one[s]  = RESET_ONE[s];
    end
    return m;
  endfunction

  // live states that cannot be reached from the current state; the current
  // state counts as reached even when deleted, but a deleted state leads nowhere
  function automatic state_mask_t garbage_of(table_image_t m);
    state_mask_t seen;
    seen = '0;
    seen[m.cur] = 1'b1;
    for (int p = 0; p < NUM_STATES; p++)
      for (int s = 0; s < NUM_STATES; s++)
        if (seen[s] && !m.dead[s]) begin
          seen[m.on_zero[s]] = 1'b1;
          seen[m.on_one[s]]  = 1'b1;
        end
    return ~seen & ~m.dead;
  endfunction

  // applies one command to the image and returns the result it should produce
  function automatic res_pld_t exec_command(inout table_image_t m, input cmd_pld_t c);
    res_pld_t    r;
    state_mask_t g;
    r = '0;
    r.status = STS_DONE;
    case (c.command)
      CMD_STEP: begin
        if (m.dead[m.cur]) r.status = STS_IGNORED;
        else m.cur = c.path_bit ? m.on_one[m.cur] : m.on_zero[m.cur];
      end
      CMD_CHANGE: begin
        if (m.dead[m.cur]) r.status = STS_IGNORED;
        else if (c.path_bit) m.on_one[m.cur] = c.target_state;
        else m.on_zero[m.cur] = c.target_state;
      end
      CMD_IDENTIFY: begin
        m.garb    = garbage_of(m);
        m.garb_ok = 1'b1;
      end
      CMD_DEL_GARB: begin
        // a stale set may name states that are already gone, they simply stay gone
        if (m.garb_ok) begin
          m.dead    = m.dead | m.garb;
          r.status  = (m.garb != '0) ? STS_DELETED : STS_NONE;
          m.garb_ok = 1'b0;
        end else begin
          r.status = STS_NONE;
        end
      end
      CMD_DEL_ONE: begin
        g = garbage_of(m);
        if (g[c.state_index]) begin
          m.dead[c.state_index] = 1'b1;
          r.status = STS_DELETED;
        end else begin
          r.status = STS_NONE;
        end
      end
      CMD_READ: begin
        r.row_next_zero = m.on_zero[c.state_index];
        r.row_next_one  = m.on_one[c.state_index];
        r.row_deleted   = m.dead[c.state_index];
      end
      default: r.status = STS_IGNORED;
    endcase
    r.cur_state    = m.cur;
    r.garbage_mask = m.garb_ok ? m.garb : '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_cmd(input logic [2:0] op, input logic pb, input state_idx_t tgt,
                           input state_idx_t idx);
    cmd_pld_t c;
    c = '{command: op, path_bit: pb, target_state: tgt, state_index: idx};
    void'(exec_command(plan_img, c));
    cmd_backlog.push_back(c);
  endtask

  task automatic report(input string what);
    $display("tb_top: mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic check_result(input res_pld_t got);
    res_pld_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      report($sformatf("result %0d arrived with nothing outstanding", results_seen));
    end else begin
      want = pending_results.pop_front();
      if (got.cur_state !== want.cur_state)
        report($sformatf("result %0d cur_state %0d, want %0d", results_seen,
                         got.cur_state, want.cur_state));
      if (got.row_next_zero !== want.row_next_zero)
        report($sformatf("result %0d row_next_zero %0d, want %0d", results_seen,
                         got.row_next_zero, want.row_next_zero));
      if (got.row_next_one !== want.row_next_one)
        report($sformatf("result %0d row_next_one %0d, want %0d", results_seen,
                         got.row_next_one, want.row_next_one));
      if (got.row_deleted !== want.row_deleted)
        report($sformatf("result %0d row_deleted %0d, want %0d", results_seen,
                         got.row_deleted, want.row_deleted));
      if (got.garbage_mask !== want.garbage_mask)
        report($sformatf("result %0d garbage_mask %02h, want %02h", results_seen,
                         got.garbage_mask, want.garbage_mask));
      if (got.status !== want.status)
        report($sformatf("result %0d status %0d, want %0d", results_seen,
                         got.status, want.status));
    end
  endtask

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // command driver: one item held until its transfer, then a drawn gap
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_ch.valid   <= 1'b0;
      cmd_ch.payload <= '0;
      src_wait       <= 0;
      src_burst      <= 1'b0;
      tracked_img     = image_after_reset();
    end else begin
      // prediction happens at the transfer, so results line up with acceptance order
      if (cmd_ch.valid && cmd_ch.ready) begin
        pending_results.push_back(exec_command(tracked_img, cmd_ch.payload));
        cmds_taken++;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (src_wait != 0) begin
          cmd_ch.valid <= 1'b0;
          src_wait     <= src_wait - 1;
        end else if (cmd_backlog.size() != 0) begin
          cmd_ch.valid   <= 1'b1;
          cmd_ch.payload <= cmd_backlog.pop_front();
          // gap after this item; bursts switch the gaps off for a while
          src_wait <= src_burst ? 0 : $urandom_range(0, MAX_WAIT);
          if ($urandom_range(0, 39) == 0) src_burst <= !src_burst;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: checks each transfer, then holds ready low for a drawn
  // number of cycles counted while a result is on offer
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      snk_wait     <= 0;
      snk_burst    <= 1'b1;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        check_result(res_ch.payload);
        snk_draw = snk_burst ? 0 : $urandom_range(0, MAX_WAIT);
        snk_wait     <= snk_draw;
        res_ch.ready <= (snk_draw == 0);
        if ($urandom_range(0, 39) == 0) snk_burst <= !snk_burst;
      end else if (snk_wait != 0) begin
        if (res_ch.valid) snk_wait <= snk_wait - 1;
        res_ch.ready <= res_ch.valid && (snk_wait == 1);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: a run that stops moving is a failure
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: no transfer for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pending_results.size());
        $display("tb_top: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------

  initial begin
    table_image_t probe;
    logic [2:0]   op;
    logic         pb;
    state_idx_t   tgt;
    state_idx_t   idx;
    state_idx_t   home;
    state_idx_t   other;
    int           pick;

    rst_ni   = 1'b0;
    plan_img = image_after_reset();

    // directed opening, walked by hand from the reset table (start in B)
    queue_cmd(CMD_DEL_GARB, 1'b0, 3'd0, 3'd0);   // no set identified yet
    queue_cmd(CMD_IDENTIFY, 1'b0, 3'd0, 3'd0);   // whole table reachable: empty set
    queue_cmd(CMD_DEL_GARB, 1'b0, 3'd0, 3'd0);   // valid but empty set
    queue_cmd(CMD_READ, 1'b0, 3'd0, 3'd0);
    queue_cmd(CMD_READ, 1'b1, 3'd7, 3'd7);
    queue_cmd(CMD_SPARE_6, 1'b1, 3'd7, 3'd7);
    queue_cmd(CMD_SPARE_7, 1'b0, 3'd0, 3'd0);
    queue_cmd(CMD_STEP, 1'b0, 3'd0, 3'd0);       // B to H
    queue_cmd(CMD_STEP, 1'b1, 3'd0, 3'd0);       // H to A
    queue_cmd(CMD_DEL_ONE, 1'b0, 3'd0, 3'd0);    // the current state is never garbage
    queue_cmd(CMD_STEP, 1'b0, 3'd0, 3'd0);       // A to D
    queue_cmd(CMD_STEP, 1'b0, 3'd0, 3'd0);       // D to C
    queue_cmd(CMD_CHANGE, 1'b1, 3'd7, 3'd0);
    queue_cmd(CMD_CHANGE, 1'b1, 3'd2, 3'd0);
    // C was the only way into E, so E drops out of reach
    queue_cmd(CMD_CHANGE, 1'b0, 3'd3, 3'd0);
    queue_cmd(CMD_IDENTIFY, 1'b0, 3'd0, 3'd0);
    queue_cmd(CMD_DEL_ONE, 1'b0, 3'd0, 3'd4);    // E is unreachable and live
    queue_cmd(CMD_DEL_ONE, 1'b0, 3'd0, 3'd4);    // already gone
    queue_cmd(CMD_READ, 1'b0, 3'd0, 3'd4);       // deleted row still reads back
    queue_cmd(CMD_DEL_GARB, 1'b0, 3'd0, 3'd0);   // stale set holding a deleted state
    queue_cmd(CMD_CHANGE, 1'b0, 3'd0, 3'd0);
    queue_cmd(CMD_READ, 1'b0, 3'd0, 3'd2);

    // random part: mostly edits and walks, with identify/delete pairs; a deletion
    // that would eat too far into the machine is turned into a read instead
    for (int k = 0; k < RANDOM_CMDS; k++) begin
      pick = $urandom_range(0, 99);
      pb   = 1'($urandom_range(0, 1));
      tgt  = state_idx_t'($urandom_range(0, 7));
      idx  = state_idx_t'($urandom_range(0, 7));
      if (pick < 30) op = CMD_STEP;
      else if (pick < 50) op = CMD_CHANGE;
      else if (pick < 62) op = CMD_READ;
      else if (pick < 72) op = CMD_IDENTIFY;
      else if (pick < 80) begin
        queue_cmd(CMD_IDENTIFY, pb, tgt, idx);
        op = CMD_DEL_GARB;
      end
      else if (pick < 92) op = CMD_DEL_ONE;
      else if (pick < 96) op = CMD_DEL_GARB;
      else op = $urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6;
      probe = plan_img;
      void'(exec_command(probe, '{command: op, path_bit: pb, target_state: tgt,
                                  state_index: idx}));
      if (probe.dead != plan_img.dead &&
          ($countones(~probe.dead) < MIN_LIVE || probe.dead[probe.cur] ||
           $urandom_range(0, 3) != 0))
        op = CMD_READ;
      queue_cmd(op, pb, tgt, idx);
    end

    // closing sequence: once the current state is deleted nothing can move again,
    // so this comes last; a stale set is used to delete the state we stand on
    home = plan_img.cur;
    other = home;
    for (int s = NUM_STATES - 1; s >= 0; s--)
      if (!plan_img.dead[s] && state_idx_t'(s) != home) other = state_idx_t'(s);
    queue_cmd(CMD_CHANGE, 1'b0, home, 3'd0);
    queue_cmd(CMD_CHANGE, 1'b1, home, 3'd0);     // self loops: only home reachable
    queue_cmd(CMD_IDENTIFY, 1'b0, 3'd0, 3'd0);
    queue_cmd(CMD_CHANGE, 1'b0, other, 3'd0);
    queue_cmd(CMD_STEP, 1'b0, 3'd0, 3'd0);       // now standing in a garbage state
    queue_cmd(CMD_DEL_GARB, 1'b0, 3'd0, 3'd0);   // deletes the current state too
    queue_cmd(CMD_STEP, 1'b1, 3'd0, 3'd0);       // ignored from a deleted state
    queue_cmd(CMD_CHANGE, 1'b1, 3'd5, 3'd0);     // ignored as well
    queue_cmd(CMD_READ, 1'b0, 3'd0, other);
    queue_cmd(CMD_IDENTIFY, 1'b0, 3'd0, 3'd0);   // reach stops at the deleted current state
    queue_cmd(CMD_DEL_ONE, 1'b0, 3'd0, home);
    queue_cmd(CMD_DEL_GARB, 1'b0, 3'd0, 3'd0);
    queue_cmd(CMD_IDENTIFY, 1'b0, 3'd0, 3'd0);
    queue_cmd(CMD_READ, 1'b1, 3'd0, home);
    deletions = $countones(plan_img.dead);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: everything driven, every prediction matched, then a quiet tail
    while (cmd_backlog.size() != 0 || cmd_ch.valid || pending_results.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("tb_top: %0d commands accepted, %0d results checked", cmds_taken,
             results_seen);
    $display("tb_top: %0d of %0d states deleted by the end, last current state %0d",
             deletions, NUM_STATES, tracked_img.cur);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
